// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the stepper phase sequencer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sps_pkg.sv =====
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, tables and constants of the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_STEP_ANGLE = 2'd0;
    localparam logic [1:0] CFG_GEAR_RATIO = 2'd1;
    localparam logic [1:0] CFG_MIN_IVL    = 2'd2;
    localparam logic [1:0] CFG_MAX_IVL    = 2'd3;

    // opcodes
    localparam logic OP_SET_SPEED = 1'b0;
    localparam logic OP_STEP_TICK = 1'b1;

    // mode selector codes
    localparam logic [1:0] SEL_KEEP = 2'd0;
    localparam logic [1:0] SEL_FULL = 2'd1;
    localparam logic [1:0] SEL_HALF = 2'd2;

    // clamp status codes
    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_MIN  = 2'd1;
    localparam logic [1:0] CLAMP_MAX  = 2'd2;

    // interval numerator scale per mode
    localparam logic [23:0] K_FULL = 24'd10000000;
    localparam logic [23:0] K_HALF = 24'd5000000;

    localparam logic [31:0] IVL_RESET  = 32'd1000000;
    localparam logic [31:0] IVL_SAT    = 32'hFFFF_FFFF;
    localparam logic [2:0]  LIMIT_FULL = 3'd3;
    localparam logic [2:0]  LIMIT_HALF = 3'd7;

    localparam logic [3:0] FULL_TAB [4] = '{4'hA, 4'h6, 4'h5, 4'h9};
    localparam logic [3:0] HALF_TAB [8] = '{4'hA, 4'h2, 4'h6, 4'h4,
                                            4'h5, 4'h1, 4'h9, 4'h8};

    // commit request from the sequencer to the phase state
    typedef struct packed {
        logic tick;      // step tick: drive pins, move index
        logic set_speed; // set-speed: take new mode
        logic mode;      // new drive mode, 1 = half step
        logic nonzero;   // speed was non-zero: take direction and limit
        logic neg;       // speed was negative
    } phase_ctl_t;

endpackage

// ===== design/sps_mul.sv =====
// ----------------------------------------------------------------------------
// sps_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sps_mul #(
    parameter int MC_W = 24,
    parameter int ML_W = 12,
    parameter int P_W  = 36
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [MC_W-1:0] mcand,
    input  logic [ML_W-1:0] mplier,
    output logic            busy,
    output logic [P_W-1:0]  product
);
    localparam int CNT_W = $clog2(ML_W + 1);

    logic [P_W-1:0]   acc_reg,  acc_next;
    logic [P_W-1:0]   mc_reg,   mc_next;
    logic [ML_W-1:0]  ml_reg,   ml_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        ml_next   = ml_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = P_W'(mcand);
            ml_next   = mplier;
            cnt_next  = CNT_W'(ML_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ml_reg[0])
                acc_next = acc_reg + mc_reg;
            mc_next  = {mc_reg[P_W-2:0], 1'b0};
            ml_next  = {1'b0, ml_reg[ML_W-1:1]};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        ml_reg  <= ml_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

// ===== design/sps_div.sv =====
// ----------------------------------------------------------------------------
// sps_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives all ones.
// ----------------------------------------------------------------------------
module sps_div #(
    parameter int N_W = 36,
    parameter int D_W = 28
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg,  quo_next;   // dividend bits out on top, quotient in
    logic [D_W-1:0]   rem_reg,  rem_next;
    logic [D_W-1:0]   den_reg,  den_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;

    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         ge;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(N_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            quo_next = {quo_reg[N_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/sps_phase.sv =====
// ----------------------------------------------------------------------------
// sps_phase
// Phase index, wrap limit, direction, drive mode and coil pin state.
// ----------------------------------------------------------------------------
module sps_phase (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  sps_pkg::phase_ctl_t ctl,
    output logic               drive_mode,
    output logic [3:0]         pins_next
);
    import sps_pkg::*;

    logic [2:0] idx_reg,   idx_next;
    logic [2:0] limit_reg, limit_next;
    logic       mode_reg,  mode_next;
    logic       rev_reg,   rev_next;
    logic [3:0] pin_reg;

    // pins driven by a tick; index has no entry in the full table above 3
    always_comb
    begin
        pins_next = pin_reg;
        if (ctl.tick)
        begin
            if (mode_reg)
                pins_next = HALF_TAB[idx_reg];
            else if (!idx_reg[2])
                pins_next = FULL_TAB[idx_reg[1:0]];
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        limit_next = limit_reg;
        mode_next  = mode_reg;
        rev_next   = rev_reg;
        if (ctl.tick)
        begin
            if (!rev_reg)
                idx_next = (idx_reg < limit_reg) ? idx_reg + 3'd1 : 3'd0;
            else
                idx_next = (idx_reg != 3'd0) ? idx_reg - 3'd1 : limit_reg;
        end
        if (ctl.set_speed)
        begin
            mode_next = ctl.mode;
            if (ctl.nonzero)
            begin
                rev_next   = ctl.neg;
                limit_next = ctl.mode ? LIMIT_HALF : LIMIT_FULL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            limit_reg <= LIMIT_FULL;
            mode_reg  <= 1'b0;
            rev_reg   <= 1'b0;
            pin_reg   <= 4'h0;
        end
        else if (commit)
        begin
            idx_reg   <= idx_next;
            limit_reg <= limit_next;
            mode_reg  <= mode_next;
            rev_reg   <= rev_next;
            pin_reg   <= pins_next;
        end
    end

    assign drive_mode = mode_reg;

endmodule

// ===== design/stepper_phase_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Bipolar stepper phase sequencer: set-speed commands and step ticks in,
// coil pins, clamped step interval and clamp status out.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata: speed, mode select; tuser: opcode
//  m_*       out  tvalid/tready      tdata: coil pins, interval, clamp status
//  cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
//  Steps: step tick accept, write-back; set-speed with zero speed accept,
//  clamp, write-back; set-speed with non-zero speed accept, shift-add
//  multiply, hand-off, restoring divide, hand-off, clamp, write-back;
//  the serial divider is the longest step.
//  One item at a time; the output register lets the next item in while the
//  last result waits. A stalled output holds the write-back state.
//  Reset (async, rst_n low) restores control, config and interval registers, not payload.
//
`include "assert_macros.svh"

module stepper_phase_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] speed_tenths_rpm, [17:16] step_mode_sel
    input  logic        s_tuser,   // [0] opcode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [3:0] coil_pins, [35:4] step_interval_us,
                                   // [37:36] clamp_status
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sps_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MUL   = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_CLAMP = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [11:0] angle_reg;
    logic [9:0]  gear_reg;
    logic [31:0] min_reg;
    logic [31:0] max_reg;

    // architectural interval state
    logic [31:0] interval_reg;
    logic [1:0]  clamp_reg;

    // current item
    logic        item_tick_reg;
    logic        item_mode_reg;
    logic        item_neg_reg;
    logic        item_nz_reg;
    logic [31:0] res_ivl_reg;
    logic [1:0]  res_clamp_reg;

    // output register
    logic        m_tvalid_reg;
    logic [39:0] m_tdata_reg;

    // input decode
    logic        accept;
    logic [15:0] in_speed;
    logic [1:0]  in_sel;
    logic        in_neg;
    logic [16:0] in_mag;
    logic [17:0] in_mag6;
    logic        in_mode;
    logic        start_calc;

    // datapath
    logic        drive_mode;
    logic [3:0]  pins_next;
    logic        num_busy, den_busy, div_busy;
    logic [35:0] num;
    logic [27:0] den;
    logic [35:0] quo;
    logic        div_start;
    logic [31:0] ivl_src;
    logic        out_free;
    logic        commit;
    phase_ctl_t  pctl;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign in_speed = s_tdata[15:0];
    assign in_sel   = s_tdata[17:16];
    assign in_neg   = in_speed[15];
    // -32768 gives 32768, hence the extra bit
    assign in_mag   = in_neg ? 17'(-$signed({in_speed[15], in_speed}))
                             : {1'b0, in_speed};
    assign in_mag6  = 18'({in_mag, 2'b00}) + 18'({in_mag, 1'b0});

    always_comb
    begin
        case (in_sel)
            SEL_FULL: in_mode = 1'b0;
            SEL_HALF: in_mode = 1'b1;
            default:  in_mode = drive_mode;   // keep, and the unused code
        endcase
    end

    assign start_calc = accept && (s_tuser == OP_SET_SPEED) && (in_mag != 17'd0);

    // numerator: K * step_angle
    sps_mul #(.MC_W(24), .ML_W(12), .P_W(36)) u_num_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_calc),
        .mcand   (in_mode ? K_HALF : K_FULL),
        .mplier  (angle_reg),
        .busy    (num_busy),
        .product (num)
    );

    // denominator: 6 * |speed| * gear_ratio
    sps_mul #(.MC_W(18), .ML_W(10), .P_W(28)) u_den_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_calc),
        .mcand   (in_mag6),
        .mplier  (gear_reg),
        .busy    (den_busy),
        .product (den)
    );

    assign div_start = (state_reg == ST_MUL) && !num_busy && !den_busy;

    sps_div #(.N_W(36), .D_W(28)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num),
        .divisor  (den),
        .busy     (div_busy),
        .quotient (quo)
    );

    // saturate the 36-bit quotient, or re-clamp the kept interval
    assign ivl_src = !item_nz_reg ? interval_reg
                   : ((quo[35:32] != 4'd0) ? IVL_SAT : quo[31:0]);

    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_WRITE) && out_free;

    assign pctl.tick      = item_tick_reg;
    assign pctl.set_speed = !item_tick_reg;
    assign pctl.mode      = item_mode_reg;
    assign pctl.nonzero   = item_nz_reg;
    assign pctl.neg       = item_neg_reg;

    sps_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .commit     (commit),
        .ctl        (pctl),
        .drive_mode (drive_mode),
        .pins_next  (pins_next)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_STEP_TICK)
                        state_next = ST_WRITE;
                    else if (start_calc)
                        state_next = ST_MUL;
                    else
                        state_next = ST_CLAMP;
                end
            end
            ST_MUL:   if (div_start) state_next = ST_DIV;
            ST_DIV:   if (!div_busy) state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_WRITE;
            ST_WRITE: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            angle_reg    <= 12'd18;
            gear_reg     <= 10'd1;
            min_reg      <= 32'd1000;
            max_reg      <= 32'd1000000;
            interval_reg <= IVL_RESET;
            clamp_reg    <= CLAMP_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEP_ANGLE: angle_reg <= cfg_data[11:0];
                    CFG_GEAR_RATIO: gear_reg  <= cfg_data[9:0];
                    CFG_MIN_IVL:    min_reg   <= cfg_data;
                    CFG_MAX_IVL:    max_reg   <= cfg_data;
                    default:        ;
                endcase
            end

            if (commit && !item_tick_reg)
            begin
                interval_reg <= res_ivl_reg;
                clamp_reg    <= res_clamp_reg;
            end

            if (commit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_tick_reg <= (s_tuser == OP_STEP_TICK);
            item_mode_reg <= in_mode;
            item_neg_reg  <= in_neg;
            item_nz_reg   <= (in_mag != 17'd0);
        end

        // min test first: if min is above max, a value below min takes min and any other takes max
        if (state_reg == ST_CLAMP)
        begin
            if (ivl_src < min_reg)
            begin
                res_ivl_reg   <= min_reg;
                res_clamp_reg <= CLAMP_MIN;
            end
            else if (ivl_src > max_reg)
            begin
                res_ivl_reg   <= max_reg;
                res_clamp_reg <= CLAMP_MAX;
            end
            else
            begin
                res_ivl_reg   <= ivl_src;
                res_clamp_reg <= CLAMP_NONE;
            end
        end

        if (commit)
        begin
            if (item_tick_reg)
                m_tdata_reg <= {2'b00, clamp_reg, interval_reg, pins_next};
            else
                m_tdata_reg <= {2'b00, res_clamp_reg, res_ivl_reg, pins_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- assertions ----
    `SPS_ASSERT_NEXT(a_tick_direct, clk, rst_n, accept && (s_tuser == OP_STEP_TICK),
        state_reg == ST_WRITE, "step tick did not go straight to write-back")
    `SPS_ASSERT_NOW(a_div_after_mul, clk, rst_n, state_reg == ST_DIV,
        !num_busy && !den_busy, "divider running while a multiplier is busy")
    `SPS_ASSERT_NOW(a_load_in_write, clk, rst_n, $rose(m_tvalid_reg),
        $past(state_reg) == ST_WRITE, "result loaded outside write-back")
    `SPS_ASSERT_NOW(a_clamp_code, clk, rst_n, 1'b1,
        clamp_reg != 2'd3, "clamp status holds an undefined code")

endmodule
